### rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int PIXEL_W = 12;
    localparam int CNT_W   = 16;
    localparam int WORD_W  = 32;
    localparam int STEP_W  = 28;
    localparam int PROD_W  = 64;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_MAX_ITER  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_RE = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_IM = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_RE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_IM   = 3'd4;

    localparam logic [CNT_W-1:0]  RST_MAX_ITER  = 16'd4096;
    localparam logic [WORD_W-1:0] RST_ORIGIN_RE = 32'hE000_0000;
    localparam logic [WORD_W-1:0] RST_ORIGIN_IM = 32'hECCC_CCCD;
    localparam logic [STEP_W-1:0] RST_STEP_RE   = 28'd419430;
    localparam logic [STEP_W-1:0] RST_STEP_IM   = 28'd596523;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic [CNT_W-1:0] iteration_count;
        logic             inside_set;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0]         max_iter;
        logic signed [WORD_W-1:0] origin_re;
        logic signed [WORD_W-1:0] origin_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
    } cfg_t;

endpackage

### rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time unit.
// A request on the s_ channel carries one pixel (pixel_x, pixel_y). The unit forms
// c = origin + pixel * step, iterates z = z*z + c from z = 0 in signed fixed point,
// and returns one result on the m_ channel: the iteration count and an in-set flag.
// The APB port holds max_iter, origin_re, origin_im, step_re and step_im at byte
// addresses 0, 4, 8, 12 and 16; write them only while the unit is idle.
// One 32x32 multiplier is shared by all products. Setting up c forms the products
// pixel_x*step_re and pixel_y*step_im, and each iteration forms three products
// (zr*zr, zi*zi, zr*zi) and then, unless z escapes, the update. The cap defaults
// to 4096.
// The unit handles one pixel at a time; s_ready is high only while it is idle.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; if the receiver stalls, the next finished result
// waits in the sequencer until the register frees.
// Synchronous reset restores the default register values, drops any request in
// flight and clears m_valid.
module mandelbrot_escape_time_unit #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mbe_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mbe_pkg::out_t               m_data
);
    import mbe_pkg::*;

    cfg_t                     cfg;
    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    mbe_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbe_mult u_mult (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    mbe_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .mul_p   (mul_p)
    );

endmodule

### rtl/mbe_cfg_regs.sv
`timescale 1ns / 1ps

module mbe_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mbe_pkg::cfg_t               cfg
);
    import mbe_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_MAX_ITER:  cfg_next.max_iter  = pwdata[CNT_W-1:0];
                REG_ORIGIN_RE: cfg_next.origin_re = pwdata[WORD_W-1:0];
                REG_ORIGIN_IM: cfg_next.origin_im = pwdata[WORD_W-1:0];
                REG_STEP_RE:   cfg_next.step_re   = pwdata[STEP_W-1:0];
                REG_STEP_IM:   cfg_next.step_im   = pwdata[STEP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_iter  <= RST_MAX_ITER;
            cfg_reg.origin_re <= RST_ORIGIN_RE;
            cfg_reg.origin_im <= RST_ORIGIN_IM;
            cfg_reg.step_re   <= RST_STEP_RE;
            cfg_reg.step_im   <= RST_STEP_IM;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAX_ITER:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.max_iter};
            REG_ORIGIN_RE: prdata = cfg_reg.origin_re;
            REG_ORIGIN_IM: prdata = cfg_reg.origin_im;
            REG_STEP_RE:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.step_re};
            REG_STEP_IM:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.step_im};
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mbe_mult.sv
`timescale 1ns / 1ps

module mbe_mult (
    input  logic                               aclk,
    input  logic signed [mbe_pkg::WORD_W-1:0]  mul_a,
    input  logic signed [mbe_pkg::WORD_W-1:0]  mul_b,
    output logic signed [mbe_pkg::PROD_W-1:0]  mul_p
);
    import mbe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_p = prod_reg;

endmodule

### rtl/mbe_core.sv
`timescale 1ns / 1ps

module mbe_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mbe_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mbe_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mbe_pkg::out_t                      m_data,
    output logic signed [mbe_pkg::WORD_W-1:0]  mul_a,
    output logic signed [mbe_pkg::WORD_W-1:0]  mul_b,
    input  logic signed [mbe_pkg::PROD_W-1:0]  mul_p
);
    import mbe_pkg::*;

    localparam int USED_BITS = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam logic [PIXEL_W-1:0] PX_MASK = PIXEL_W'((64'd1 << USED_BITS) - 64'd1);
    localparam int THR_SHIFT = 2 * FRAC_BITS + 2;
    localparam bit CAN_ESCAPE = (THR_SHIFT < PROD_W);
    localparam logic [PROD_W-1:0] THRESH =
        CAN_ESCAPE ? (64'd1 << (THR_SHIFT % PROD_W)) : 64'd0;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CRE  = 4'd1;
    localparam logic [3:0] ST_CIM  = 4'd2;
    localparam logic [3:0] ST_CFIN = 4'd3;
    localparam logic [3:0] ST_RR   = 4'd4;
    localparam logic [3:0] ST_II   = 4'd5;
    localparam logic [3:0] ST_RI   = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        begin
            if (!v[PROD_W-1] && (|v[PROD_W-2:WORD_W-1])) begin
                r = 32'sh7FFF_FFFF;
            end else if (v[PROD_W-1] && !(&v[PROD_W-2:WORD_W-1])) begin
                r = 32'sh8000_0000;
            end else begin
                r = v[WORD_W-1:0];
            end
            sat32 = r;
        end
    endfunction

    logic [3:0]               state_reg, state_next;
    logic [PIXEL_W-1:0]       px_reg, py_reg;
    logic signed [WORD_W-1:0] c_re_reg, c_im_reg;
    logic signed [WORD_W-1:0] zr_reg, zi_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [PROD_W-1:0]        rr_reg;
    logic signed [PROD_W-1:0] diff_reg;
    logic                     m_valid_reg, m_valid_next;
    out_t                     m_data_reg;

    logic                     accept;
    logic                     load_out;
    logic [PROD_W-1:0]        mag_sum;
    logic                     escape;
    logic [CNT_W-1:0]         count_inc;
    logic signed [PROD_W-1:0] c_re_sum, c_im_sum;
    logic signed [PROD_W-1:0] zr_sum, zi_sum;

    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign mag_sum   = rr_reg + $unsigned(mul_p);
    assign escape    = CAN_ESCAPE && (mag_sum > THRESH);
    assign count_inc = count_reg + 1'b1;

    assign c_re_sum = $signed({{(PROD_W-WORD_W){cfg.origin_re[WORD_W-1]}}, cfg.origin_re})
                      + mul_p;
    assign c_im_sum = $signed({{(PROD_W-WORD_W){cfg.origin_im[WORD_W-1]}}, cfg.origin_im})
                      + mul_p;
    // The cross product carries one extra factor of two, so it drops one less bit.
    assign zr_sum = (diff_reg >>> FRAC_BITS)
                    + $signed({{(PROD_W-WORD_W){c_re_reg[WORD_W-1]}}, c_re_reg});
    assign zi_sum = (mul_p >>> (FRAC_BITS - 1))
                    + $signed({{(PROD_W-WORD_W){c_im_reg[WORD_W-1]}}, c_im_reg});

    // Operand select for the shared multiplier; its product shows up in the next cycle.
    always_comb begin
        unique case (state_reg)
            ST_CRE: begin
                mul_a = $signed({{(WORD_W-PIXEL_W){1'b0}}, px_reg});
                mul_b = $signed({{(WORD_W-STEP_W){1'b0}}, cfg.step_re});
            end
            ST_CIM: begin
                mul_a = $signed({{(WORD_W-PIXEL_W){1'b0}}, py_reg});
                mul_b = $signed({{(WORD_W-STEP_W){1'b0}}, cfg.step_im});
            end
            ST_RR: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_II: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            ST_RI: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CRE;
            ST_CRE:  state_next = ST_CIM;
            ST_CIM:  state_next = ST_CFIN;
            ST_CFIN: state_next = (cfg.max_iter == '0) ? ST_DONE : ST_RR;
            ST_RR:   state_next = ST_II;
            ST_II:   state_next = ST_RI;
            ST_RI:   state_next = escape ? ST_DONE : ST_UPD;
            ST_UPD:  state_next = (count_inc == cfg.max_iter) ? ST_DONE : ST_RR;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= s_data.pixel_x & PX_MASK;
            py_reg    <= s_data.pixel_y & PX_MASK;
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (state_reg == ST_CIM) begin
            c_re_reg <= sat32(c_re_sum);
        end
        if (state_reg == ST_CFIN) begin
            c_im_reg <= sat32(c_im_sum);
        end
        if (state_reg == ST_II) begin
            rr_reg <= $unsigned(mul_p);
        end
        if (state_reg == ST_RI) begin
            diff_reg <= $signed(rr_reg) - mul_p;
        end
        if (state_reg == ST_UPD) begin
            zr_reg    <= sat32(zr_sum);
            zi_reg    <= sat32(zi_sum);
            count_reg <= count_inc;
        end
        if (load_out) begin
            m_data_reg.iteration_count <= count_reg;
            m_data_reg.inside_set      <= (count_reg == cfg.max_iter);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/mbe_checker.sv
`timescale 1ns / 1ps

module mbe_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input mbe_pkg::out_t m_data
);
    import mbe_pkg::*;

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // Once a request is taken, s_ready falls as the unit turns busy.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after a request was accepted");

    // A new result only appears while the sequencer is busy with a pixel.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a pixel in progress");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### bench/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit_tb;
    import mbe_pkg::*;

    localparam int  FRAC          = 28;
    localparam int  HALF_PERIOD   = 6;
    localparam int  RESET_CYCLES  = 11;
    localparam int  IDLE_PERCENT  = 29;
    localparam int  HOLD_CYCLES   = 600;
    localparam int  SETTLE_CYCLES = 12;
    localparam int  QUIET_LIMIT   = 1000000;

    localparam longint      WORD_MAX     = 64'sd2147483647;
    localparam longint      WORD_MIN     = -64'sd2147483648;
    // |z|^2 > 4 with 2*FRAC fraction bits
    localparam logic [63:0] ESCAPE_LIMIT = 64'd1 << (2 * FRAC + 2);

    class escape_scoreboard;
        cfg_t regs;
        out_t pending_counts[$];
        int   mismatches;

        function new();
            regs.max_iter  = RST_MAX_ITER;
            regs.origin_re = RST_ORIGIN_RE;
            regs.origin_im = RST_ORIGIN_IM;
            regs.step_re   = RST_STEP_RE;
            regs.step_im   = RST_STEP_IM;
            mismatches     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MAX_ITER:  regs.max_iter  = value[CNT_W-1:0];
                REG_ORIGIN_RE: regs.origin_re = value[WORD_W-1:0];
                REG_ORIGIN_IM: regs.origin_im = value[WORD_W-1:0];
                REG_STEP_RE:   regs.step_re   = value[STEP_W-1:0];
                REG_STEP_IM:   regs.step_im   = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_MAX) return WORD_MAX;
            if (v < WORD_MIN) return WORD_MIN;
            return v;
        endfunction

        function out_t escape_count(in_t p);
            longint      c_re, c_im, zr, zi, rr, ii, ri;
            logic [63:0] mag;
            int unsigned n;
            out_t        r;
            c_re = clamp_word(longint'($signed(regs.origin_re))
                              + longint'(p.pixel_x) * longint'(regs.step_re));
            c_im = clamp_word(longint'($signed(regs.origin_im))
                              + longint'(p.pixel_y) * longint'(regs.step_im));
            zr = 0;
            zi = 0;
            n  = 0;
            while (n < regs.max_iter) begin
                rr  = zr * zr;
                ii  = zi * zi;
                // Both squares are nonnegative and below 2^63, so the unsigned sum is exact.
                mag = rr + ii;
                if (mag > ESCAPE_LIMIT) break;
                ri = zr * zi;
                zr = clamp_word(((rr - ii) >>> FRAC) + c_re);
                zi = clamp_word((ri >>> (FRAC - 1)) + c_im);
                n++;
            end
            r.iteration_count = n[CNT_W-1:0];
            r.inside_set      = (n == regs.max_iter);
            return r;
        endfunction

        function void note_pixel(in_t p);
            pending_counts.push_back(escape_count(p));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_counts.size() == 0) begin
                $display("%0t: result with no request pending, count %0d inside %0d",
                         $time, got.iteration_count, got.inside_set);
                mismatches++;
                return;
            end
            want = pending_counts.pop_front();
            if (got.iteration_count !== want.iteration_count) begin
                $display("%0t: iteration_count expected %0d, got %0d",
                         $time, want.iteration_count, got.iteration_count);
                mismatches++;
            end
            if (got.inside_set !== want.inside_set) begin
                $display("%0t: inside_set expected %0d, got %0d",
                         $time, want.inside_set, got.inside_set);
                mismatches++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;

    escape_scoreboard sb = new();
    bit               idle_on;
    bit               hold_off_req;
    int               quiet_cycles;

    mandelbrot_escape_time_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Result checking and the watchdog both look at pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no activity for %0d cycles", $time, QUIET_LIMIT);
                    $display("mandelbrot_escape_time_unit_tb: errors");
                    $finish;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready      = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready = !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Called at a falling edge; leaves s_valid high after the request is taken.
    task automatic offer_pixel(in_t p);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = p;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(p);
        @(negedge aclk);
    endtask

    task automatic offer_xy(int x, int y);
        in_t p;
        p.pixel_x = x[PIXEL_W-1:0];
        p.pixel_y = y[PIXEL_W-1:0];
        offer_pixel(p);
    endtask

    task automatic offer_random(int count);
        in_t p;
        repeat (count) begin
            p.pixel_x = PIXEL_W'($urandom_range(4095));
            p.pixel_y = PIXEL_W'($urandom_range(4095));
            offer_pixel(p);
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending_counts.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic load_view(logic [CNT_W-1:0] cap, logic [WORD_W-1:0] ore,
                             logic [WORD_W-1:0] oim, logic [STEP_W-1:0] sre,
                             logic [STEP_W-1:0] sim);
        write_reg(REG_MAX_ITER, DATA_W'(cap));
        write_reg(REG_ORIGIN_RE, ore);
        write_reg(REG_ORIGIN_IM, oim);
        write_reg(REG_STEP_RE, DATA_W'(sre));
        write_reg(REG_STEP_IM, DATA_W'(sim));
    endtask

    initial begin
        logic [CNT_W-1:0]  cap;
        logic [WORD_W-1:0] ore, oim;
        logic [STEP_W-1:0] sre, sim;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset view at the default cap: one point near the origin stays inside.
        offer_xy(0, 0);
        offer_xy(1280, 540);
        offer_xy(4095, 0);
        offer_xy(0, 4095);
        drain_results();

        // Largest cap with c = 0 for column zero; wide columns saturate c.
        load_view(16'hFFFF, 32'h0000_0000, 32'h0000_0000, 28'hFFF_FFFF, 28'd0);
        offer_xy(0, 0);
        offer_xy(1, 0);
        offer_xy(2, 4095);
        offer_xy(4095, 4095);
        drain_results();

        // A cap of one: the single update is never tested, so every point is inside.
        load_view(16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 28'hFFF_FFFF, 28'hFFF_FFFF);
        offer_xy(0, 0);
        offer_xy(4095, 4095);
        drain_results();

        load_view(16'd16, 32'h8000_0000, 32'h7FFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF);
        offer_xy(0, 0);
        offer_xy(4095, 4095);
        offer_xy(2048, 1);
        drain_results();

        // A zero cap does no update at all.
        load_view(16'd0, 32'h0000_0000, 32'h0000_0000, 28'd1000, 28'd1000);
        offer_xy(7, 9);
        offer_xy(4095, 0);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            idle_on = (ph != 2);
            if (ph == 4) begin
                cap = CNT_W'($urandom_range(1, 64));
                ore = $urandom;
                oim = $urandom;
                sre = STEP_W'($urandom);
                sim = STEP_W'($urandom);
            end else begin
                cap = (ph == 5) ? CNT_W'($urandom_range(100, 600))
                                : CNT_W'($urandom_range(1, 40));
                // Windows around the set: real part from -2.5 to 0.5, imaginary -1.5 to 0.5.
                ore = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
                oim = $urandom_range(0, 32'h2000_0000) - 32'h1800_0000;
                sre = STEP_W'($urandom_range(60000, 260000));
                sim = STEP_W'($urandom_range(60000, 260000));
            end
            load_view(cap, ore, oim, sre, sim);
            // The receiver stalls long enough for the unit to fill and block new requests.
            if (ph == 3) hold_off_req = 1'b1;
            offer_random(21);
            drain_results();
        end

        idle_on = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending_counts.size() == 0) begin
            $display("mandelbrot_escape_time_unit_tb: clean");
        end else begin
            $display("mandelbrot_escape_time_unit_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/mbe_pkg.sv
rtl/mbe_cfg_regs.sv
rtl/mbe_mult.sv
rtl/mbe_core.sv
rtl/mandelbrot_escape_time_unit.sv
rtl/mbe_checker.sv
bench/mandelbrot_escape_time_unit_tb.sv
